### sv/ocalu_pkg.sv
package ocalu_pkg;

    // pipeline control shared by all arithmetic units
    typedef struct packed {
        logic adv;     // every stage moves one step
        logic in_vld;  // an item enters stage zero on this step
    } t_pipe_ctl;

endpackage

### sv/ocalu_addsub.sv
module ocalu_addsub #(
    parameter int DATA_WIDTH = 32,
    parameter int DEPTH = 34
) (
    input  logic                          i_clk,
    input  ocalu_pkg::t_pipe_ctl          i_ctl,
    input  logic [DATA_WIDTH-1:0]         i_x,
    input  logic [DATA_WIDTH-1:0]         i_y,
    output logic [DATA_WIDTH-1:0]         o_sum,
    output logic                          o_sum_ok,
    output logic [DATA_WIDTH-1:0]         o_dif,
    output logic                          o_dif_ok
);

    logic [DATA_WIDTH-1:0] n_sum, n_dif;
    logic                  n_sum_ok, n_dif_ok;
    logic [DATA_WIDTH-1:0] r_sum [DEPTH];
    logic [DATA_WIDTH-1:0] r_dif [DEPTH];
    logic                  r_sum_ok [DEPTH];
    logic                  r_dif_ok [DEPTH];

    always_comb begin
        logic [DATA_WIDTH-1:0] s, d;
        s = i_x + i_y;
        d = i_x - i_y;
        // overflow when operand signs agree (add) or differ (sub) and result sign flips
        n_sum_ok = !((i_x[DATA_WIDTH-1] == i_y[DATA_WIDTH-1]) &&
                     (s[DATA_WIDTH-1] != i_x[DATA_WIDTH-1]));
        n_dif_ok = !((i_x[DATA_WIDTH-1] != i_y[DATA_WIDTH-1]) &&
                     (d[DATA_WIDTH-1] != i_x[DATA_WIDTH-1]));
        n_sum = n_sum_ok ? s : '0;
        n_dif = n_dif_ok ? d : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_sum[0]    <= n_sum;
            r_dif[0]    <= n_dif;
            r_sum_ok[0] <= n_sum_ok;
            r_dif_ok[0] <= n_dif_ok;
            for (int k = 1; k < DEPTH; k++) begin
                r_sum[k]    <= r_sum[k-1];
                r_dif[k]    <= r_dif[k-1];
                r_sum_ok[k] <= r_sum_ok[k-1];
                r_dif_ok[k] <= r_dif_ok[k-1];
            end
        end
    end

    assign o_sum    = r_sum[DEPTH-1];
    assign o_sum_ok = r_sum_ok[DEPTH-1];
    assign o_dif    = r_dif[DEPTH-1];
    assign o_dif_ok = r_dif_ok[DEPTH-1];

endmodule

### sv/ocalu_mul.sv
module ocalu_mul #(
    parameter int DATA_WIDTH = 32,
    parameter int DEPTH = 34
) (
    input  logic                          i_clk,
    input  ocalu_pkg::t_pipe_ctl          i_ctl,
    input  logic [DATA_WIDTH-1:0]         i_x,
    input  logic [DATA_WIDTH-1:0]         i_y,
    output logic [DATA_WIDTH-1:0]         o_prod,
    output logic                          o_prod_ok
);

    localparam int TAIL = DEPTH - 3;

    logic [DATA_WIDTH-1:0]   r_mx, r_my;
    logic                    r_neg_a, r_zero_a, r_neg_b, r_zero_b;
    logic [2*DATA_WIDTH-1:0] r_prod;
    logic [DATA_WIDTH-1:0]   r_res [TAIL+1];
    logic                    r_ok  [TAIL+1];
    logic [DATA_WIDTH-1:0]   n_res;
    logic                    n_ok;

    always_comb begin
        logic [DATA_WIDTH-1:0] lo, neg_lo;
        logic                  fits;
        lo     = r_prod[DATA_WIDTH-1:0];
        neg_lo = '0 - lo;
        // magnitude limit is 2^(W-1) for a negative product, 2^(W-1)-1 otherwise
        if (r_neg_b) begin
            fits = !lo[DATA_WIDTH-1] || (lo[DATA_WIDTH-2:0] == '0);
        end else begin
            fits = !lo[DATA_WIDTH-1];
        end
        fits = fits && (r_prod[2*DATA_WIDTH-1:DATA_WIDTH] == '0);
        if (r_zero_b) begin
            n_ok  = 1'b1;
            n_res = '0;
        end else begin
            n_ok  = fits;
            n_res = fits ? (r_neg_b ? neg_lo : lo) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_mx     <= i_x[DATA_WIDTH-1] ? ('0 - i_x) : i_x;
            r_my     <= i_y[DATA_WIDTH-1] ? ('0 - i_y) : i_y;
            r_neg_a  <= i_x[DATA_WIDTH-1] ^ i_y[DATA_WIDTH-1];
            r_zero_a <= (i_x == '0) || (i_y == '0);
            r_prod   <= {{DATA_WIDTH{1'b0}}, r_mx} * {{DATA_WIDTH{1'b0}}, r_my};
            r_neg_b  <= r_neg_a;
            r_zero_b <= r_zero_a;
            r_res[0] <= n_res;
            r_ok[0]  <= n_ok;
            for (int k = 1; k <= TAIL; k++) begin
                r_res[k] <= r_res[k-1];
                r_ok[k]  <= r_ok[k-1];
            end
        end
    end

    assign o_prod    = r_res[TAIL];
    assign o_prod_ok = r_ok[TAIL];

endmodule

### sv/ocalu_div.sv
module ocalu_div #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  ocalu_pkg::t_pipe_ctl          i_ctl,
    input  logic [DATA_WIDTH-1:0]         i_x,
    input  logic [DATA_WIDTH-1:0]         i_y,
    output logic [DATA_WIDTH-1:0]         o_quo,
    output logic [DATA_WIDTH-1:0]         o_rem,
    output logic                          o_div_ok
);

    // stage 0 holds magnitudes, stages 1..W each retire one quotient bit
    logic [DATA_WIDTH-1:0] r_dvd [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] r_dsr [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] r_rem [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] r_quo [DATA_WIDTH+1];
    logic                  r_qneg [DATA_WIDTH+1];
    logic                  r_rneg [DATA_WIDTH+1];
    logic                  r_bad  [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] r_quo_out, r_rem_out;
    logic                  r_ok_out;
    logic                  n_bad;

    assign n_bad = (i_y == '0) ||
                   ((i_x == {1'b1, {(DATA_WIDTH-1){1'b0}}}) && (i_y == '1));

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_dvd[0]  <= i_x[DATA_WIDTH-1] ? ('0 - i_x) : i_x;
            r_dsr[0]  <= i_y[DATA_WIDTH-1] ? ('0 - i_y) : i_y;
            r_rem[0]  <= '0;
            r_quo[0]  <= '0;
            r_qneg[0] <= i_x[DATA_WIDTH-1] ^ i_y[DATA_WIDTH-1];
            r_rneg[0] <= i_x[DATA_WIDTH-1];
            r_bad[0]  <= n_bad;
        end
    end

    for (genvar g = 1; g <= DATA_WIDTH; g++) begin : g_step
        logic [DATA_WIDTH:0] trial, diff;
        logic                take;
        assign trial = {r_rem[g-1], r_dvd[g-1][DATA_WIDTH-1]};
        assign diff  = trial - {1'b0, r_dsr[g-1]};
        assign take  = !diff[DATA_WIDTH];
        always_ff @(posedge i_clk) begin
            if (i_ctl.adv) begin
                r_rem[g]  <= take ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
                r_quo[g]  <= {r_quo[g-1][DATA_WIDTH-2:0], take};
                r_dvd[g]  <= {r_dvd[g-1][DATA_WIDTH-2:0], 1'b0};
                r_dsr[g]  <= r_dsr[g-1];
                r_qneg[g] <= r_qneg[g-1];
                r_rneg[g] <= r_rneg[g-1];
                r_bad[g]  <= r_bad[g-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_ok_out  <= !r_bad[DATA_WIDTH];
            r_quo_out <= r_bad[DATA_WIDTH] ? '0 :
                         (r_qneg[DATA_WIDTH] ? ('0 - r_quo[DATA_WIDTH]) : r_quo[DATA_WIDTH]);
            r_rem_out <= r_bad[DATA_WIDTH] ? '0 :
                         (r_rneg[DATA_WIDTH] ? ('0 - r_rem[DATA_WIDTH]) : r_rem[DATA_WIDTH]);
        end
    end

    assign o_quo    = r_quo_out;
    assign o_rem    = r_rem_out;
    assign o_div_ok = r_ok_out;

endmodule

### sv/overflow_checked_arithmetic_top.sv
// throughput: one item per cycle while the output is not stalled; the restoring
// divider pipeline (one quotient bit per stage) sets the depth, the other units
// are delay-matched to it
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset: i_rst_n synchronous active low, clears the valid bits only
module overflow_checked_arithmetic_top #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_s_tvalid,
    output logic                                      o_s_tready,
    // left_operand, right_operand, zero pad to bytes
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]         i_s_tdata,
    output logic                                      o_m_tvalid,
    input  logic                                      i_m_tready,
    // sum_value, sum_valid, difference_value, difference_valid, product_value,
    // product_valid, quotient_value, remainder_value, division_valid, zero pad
    output logic [((5*DATA_WIDTH+4+7)/8)*8-1:0]       o_m_tdata
);

    localparam int LAT = DATA_WIDTH + 2;
    localparam int W   = DATA_WIDTH;

    ocalu_pkg::t_pipe_ctl   ctl;
    logic [LAT-1:0]         r_vld;
    logic [W-1:0]           x, y;
    logic [W-1:0]           sum, dif, prod, quo, rem;
    logic                   sum_ok, dif_ok, prod_ok, div_ok;

    // whole pipeline moves whenever the output register is empty or being taken
    assign ctl.adv    = !r_vld[LAT-1] || i_m_tready;
    assign ctl.in_vld = i_s_tvalid;
    assign o_s_tready = ctl.adv;
    assign o_m_tvalid = r_vld[LAT-1];

    assign x = i_s_tdata[W-1:0];
    assign y = i_s_tdata[2*W-1:W];

    // valid bits travel alongside the data stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ctl.adv) begin
            r_vld <= {r_vld[LAT-2:0], ctl.in_vld};
        end
    end

    ocalu_addsub #(.DATA_WIDTH(W), .DEPTH(LAT)) u_addsub (
        .i_clk(i_clk), .i_ctl(ctl), .i_x(x), .i_y(y),
        .o_sum(sum), .o_sum_ok(sum_ok), .o_dif(dif), .o_dif_ok(dif_ok)
    );

    ocalu_mul #(.DATA_WIDTH(W), .DEPTH(LAT)) u_mul (
        .i_clk(i_clk), .i_ctl(ctl), .i_x(x), .i_y(y),
        .o_prod(prod), .o_prod_ok(prod_ok)
    );

    ocalu_div #(.DATA_WIDTH(W)) u_div (
        .i_clk(i_clk), .i_ctl(ctl), .i_x(x), .i_y(y),
        .o_quo(quo), .o_rem(rem), .o_div_ok(div_ok)
    );

    // result packing, lowest field first
    always_comb begin
        o_m_tdata = '0;
        o_m_tdata[W-1:0]         = sum;
        o_m_tdata[W]             = sum_ok;
        o_m_tdata[2*W:W+1]       = dif;
        o_m_tdata[2*W+1]         = dif_ok;
        o_m_tdata[3*W+1:2*W+2]   = prod;
        o_m_tdata[3*W+2]         = prod_ok;
        o_m_tdata[4*W+2:3*W+3]   = quo;
        o_m_tdata[5*W+2:4*W+3]   = rem;
        o_m_tdata[5*W+3]         = div_ok;
    end

endmodule

### sv/ocalu_chk.sv
module ocalu_chk #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    input  logic                                  o_s_tready,
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]     i_s_tdata,
    input  logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    input  logic [((5*DATA_WIDTH+4+7)/8)*8-1:0]   o_m_tdata
);

    localparam int W = DATA_WIDTH;

    // a held result must not change while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed under stall");

    // an empty output stage never blocks input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked with empty output");

    // flagged sums and differences read as zero
    a_addsub_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (!o_m_tdata[W] || !o_m_tdata[2*W+1]) |->
        ((o_m_tdata[W] || o_m_tdata[W-1:0] == '0) &&
         (o_m_tdata[2*W+1] || o_m_tdata[2*W:W+1] == '0)))
        else $error("invalid sum or difference not zero");

    // invalid division gives zero quotient and remainder
    a_div_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[5*W+3] |->
        (o_m_tdata[4*W+2:3*W+3] == '0) && (o_m_tdata[5*W+2:4*W+3] == '0))
        else $error("invalid division not zero");

endmodule

bind overflow_checked_arithmetic_top ocalu_chk #(.DATA_WIDTH(DATA_WIDTH)) u_chk (.*);

### sim/tb_overflow_checked_arithmetic_top.sv
module tb_overflow_checked_arithmetic_top;

    localparam int W = 32;
    localparam int IN_W = ((2*W+7)/8)*8;
    localparam int OUT_W = ((5*W+4+7)/8)*8;
    localparam int LATENCY = W + 2;
    localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINUS_ONE = {W{1'b1}};

    typedef struct packed {
        logic         division_valid;
        logic [W-1:0] remainder_value;
        logic [W-1:0] quotient_value;
        logic         product_valid;
        logic [W-1:0] product_value;
        logic         difference_valid;
        logic [W-1:0] difference_value;
        logic         sum_valid;
        logic [W-1:0] sum_value;
    } arith_result_t;

    // expected results of the checked arithmetic, oldest first
    class arith_scoreboard;
        arith_result_t pending_results[$];
        int            fail_count;

        function arith_result_t compute(logic [W-1:0] x, logic [W-1:0] y);
            arith_result_t r;
            logic signed [W:0]   wide_sum;
            logic signed [W:0]   wide_diff;
            logic signed [2*W-1:0] wide_prod;
            logic [W-1:0] mx;
            logic [W-1:0] my;
            logic [W-1:0] q;
            logic [W-1:0] rem;
            r = '0;
            wide_sum = $signed({x[W-1], x}) + $signed({y[W-1], y});
            if (wide_sum[W] == wide_sum[W-1]) begin
                r.sum_value = wide_sum[W-1:0];
                r.sum_valid = 1'b1;
            end
            wide_diff = $signed({x[W-1], x}) - $signed({y[W-1], y});
            if (wide_diff[W] == wide_diff[W-1]) begin
                r.difference_value = wide_diff[W-1:0];
                r.difference_valid = 1'b1;
            end
            wide_prod = $signed({{W{x[W-1]}}, x}) * $signed({{W{y[W-1]}}, y});
            if (wide_prod[2*W-1:W-1] == {(W+1){wide_prod[W-1]}}) begin
                r.product_value = wide_prod[W-1:0];
                r.product_valid = 1'b1;
            end
            // zero divisor and most negative over minus one are invalid
            if (y != '0 && !(x == MOST_NEG && y == MINUS_ONE)) begin
                mx = x[W-1] ? -x : x;
                my = y[W-1] ? -y : y;
                q = mx / my;
                rem = mx % my;
                r.quotient_value = (x[W-1] != y[W-1]) ? -q : q;
                r.remainder_value = x[W-1] ? -rem : rem;
                r.division_valid = 1'b1;
            end
            return r;
        endfunction

        function void note_operands(logic [W-1:0] x, logic [W-1:0] y);
            pending_results.push_back(compute(x, y));
        endfunction

        function void check_result(arith_result_t got);
            arith_result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            if (got.sum_value !== want.sum_value || got.sum_valid !== want.sum_valid) begin
                $display("%0t: sum exp %h/%b got %h/%b", $time, want.sum_value,
                         want.sum_valid, got.sum_value, got.sum_valid);
                fail_count++;
            end
            if (got.difference_value !== want.difference_value ||
                got.difference_valid !== want.difference_valid) begin
                $display("%0t: difference exp %h/%b got %h/%b", $time,
                         want.difference_value, want.difference_valid,
                         got.difference_value, got.difference_valid);
                fail_count++;
            end
            if (got.product_value !== want.product_value ||
                got.product_valid !== want.product_valid) begin
                $display("%0t: product exp %h/%b got %h/%b", $time, want.product_value,
                         want.product_valid, got.product_value, got.product_valid);
                fail_count++;
            end
            if (got.quotient_value !== want.quotient_value ||
                got.remainder_value !== want.remainder_value ||
                got.division_valid !== want.division_valid) begin
                $display("%0t: division exp %h %h/%b got %h %h/%b", $time,
                         want.quotient_value, want.remainder_value, want.division_valid,
                         got.quotient_value, got.remainder_value, got.division_valid);
                fail_count++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata;   // left_operand, right_operand
    logic             o_m_tvalid;
    logic             i_m_tready;
    logic [OUT_W-1:0] o_m_tdata;   // result fields, sum_value lowest

    arith_scoreboard  board;
    logic             stimulus_done;
    logic             hold_off;

    overflow_checked_arithmetic_top #(.DATA_WIDTH(W)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return $urandom_range(0, 2) - 1;
            3: return $urandom_range(0, 255) - 128;
            4: return $urandom_range(0, 65535) - 32768;
            default: return $urandom;
        endcase
    endfunction

    // offer one item and hold it until accepted
    task automatic send_operands(logic [W-1:0] x, logic [W-1:0] y);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {{(IN_W-2*W){1'b0}}, y, x};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_operands(x, y);
    endtask

    task automatic sender_gap(int n);
        i_s_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    initial begin
        logic [W-1:0] corner[8];
        int sent;
        int burst;
        board = new();
        stimulus_done = 1'b0;
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes: zero, +-1, most negative, most positive and neighbors
        corner = '{'0, 1, MINUS_ONE, MOST_NEG, MOST_POS, MOST_NEG + 1, 2, 32'h0001_0000};
        for (int a = 0; a < 5; a++)
            for (int b = 0; b < 5; b++)
                send_operands(corner[(a*3) % 8], corner[(b*5 + a) % 8]);
        send_operands(MOST_NEG, MINUS_ONE);
        send_operands(0, MOST_NEG);
        send_operands(32'h0001_0000, 32'h0000_8000);
        send_operands(32'h0001_0000, 32'hffff_8000);
        sender_gap(1);

        sent = 0;
        while (sent < 1150) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++) begin
                send_operands(pick_operand(), pick_operand());
                sent++;
            end
            if ($urandom_range(0, 2) != 0) sender_gap($urandom_range(1, 6));
        end
        i_s_tvalid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // receiver: random stall pattern, quiet stretches, and one long hold-off
    initial begin
        int cyc;
        int mode;
        cyc = 0;
        mode = 0;
        hold_off = 1'b0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 200 == 0) mode = $urandom_range(0, 2);
            hold_off = (cyc >= 600 && cyc < 800);
            if (hold_off) i_m_tready <= 1'b0;
            else if (mode == 0) i_m_tready <= 1'b1;
            else if (mode == 1) i_m_tready <= ($urandom_range(0, 3) != 0);
            else i_m_tready <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_result(arith_result_t'(o_m_tdata[5*W+3:0]));
    end

    initial begin
        int tail;
        @(posedge i_clk);
        while (!(stimulus_done && board.pending_results.size() == 0))
            @(posedge i_clk);
        tail = 0;
        while (tail < 4 * LATENCY) begin
            @(posedge i_clk);
            tail++;
        end
        if (board.fail_count == 0)
            $display("[overflow_checked_arithmetic_top] OK");
        else
            $display("[overflow_checked_arithmetic_top] ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("[overflow_checked_arithmetic_top] ERROR");
        $finish;
    end

endmodule

### overflow_checked_arithmetic_top.f
sv/ocalu_pkg.sv
sv/ocalu_addsub.sv
sv/ocalu_mul.sv
sv/ocalu_div.sv
sv/overflow_checked_arithmetic_top.sv
sv/ocalu_chk.sv
sim/tb_overflow_checked_arithmetic_top.sv
